// ===== hdl/bmla_pkg.sv =====
package bmla_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int ATT_W     = FRAC_BITS + 1;
   localparam int DIV_W     = 32 + FRAC_BITS;
   localparam int NUM_FACES = 6;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_DIR   = 2'd1,
      KIND_POINT = 2'd2,
      KIND_EMIT  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_VIEW_X = 2'd0,
      REG_VIEW_Y = 2'd1,
      REG_VIEW_Z = 2'd2
   } reg_index_type;

   typedef struct packed {
      kind_type           kind;
      logic [2:0]         face;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [31:0] red;
      logic signed [31:0] green;
      logic signed [31:0] blue;
      logic [30:0]        light_range;
      logic [30:0]        falloff_start;
   } req_type;

   typedef struct packed {
      logic [2:0]         out_face;
      logic signed [31:0] out_red;
      logic signed [31:0] out_green;
      logic signed [31:0] out_blue;
      logic               last;
   } rsp_type;

   // item plus what the front decided about it
   typedef struct packed {
      req_type item;
      logic    load_ok;
      logic    point_skip;
   } cmd_type;

   typedef struct packed {
      logic signed [31:0] r;
      logic signed [31:0] g;
      logic signed [31:0] b;
   } rgb_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [31:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_W-1:0]   quotient;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      if (v > 50'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -50'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

// ===== hdl/bmla_front.sv =====
module bmla_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  bmla_pkg::req_type req_item,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output bmla_pkg::cmd_type cmd
);
   import bmla_pkg::*;

   localparam int DEPTH = 4;

   cmd_type    queue_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   cmd_type    incoming;
   logic       do_push, do_pop;

   always_comb begin
      incoming.item       = req_item;
      incoming.load_ok    = req_item.face <= 3'(NUM_FACES - 1);
      incoming.point_skip = req_item.light_range <= req_item.falloff_start;
   end

   assign full      = count_ff == 3'(DEPTH);
   assign cmd_valid = count_ff != 3'd0;
   assign cmd       = queue_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + 3'(do_push) - 3'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

// ===== hdl/bmla_div.sv =====
module bmla_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bmla_pkg::div_req_type req,
   output bmla_pkg::div_rsp_type rsp
);
   import bmla_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      den_ff, den_in;
   logic [32:0]      rem_shift;
   logic [33:0]      trial;

   // one quotient bit per cycle, restoring
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_W-1]};
      trial     = {1'b0, rem_shift} - {2'b00, den_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[31:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W - 1);
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== hdl/bmla_rsp_queue.sv =====
module bmla_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_push,
   input  bmla_pkg::rsp_type in_data,
   output logic              in_full,
   output logic              empty,
   input  logic              pop,
   output bmla_pkg::rsp_type rsp_item
);
   import bmla_pkg::*;

   localparam int DEPTH = 8;

   rsp_type    queue_ff [DEPTH];
   logic [2:0] wr_ptr_ff, rd_ptr_ff;
   logic [3:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign in_full  = count_ff == 4'(DEPTH);
   assign empty    = count_ff == 4'd0;
   assign rsp_item = queue_ff[rd_ptr_ff];
   assign do_push  = in_push && !in_full;
   assign do_pop   = pop && !empty;
   assign count_in = count_ff + 4'(do_push) - 4'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 3'd1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 3'd1;
         count_ff <= count_in;
      end
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== hdl/bmla_back.sv =====
module bmla_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  bmla_pkg::cmd_type     cmd,
   output logic                  cmd_pop,
   input  logic signed [31:0]    view_x,
   input  logic signed [31:0]    view_y,
   input  logic signed [31:0]    view_z,
   output bmla_pkg::div_req_type div_req,
   input  bmla_pkg::div_rsp_type div_rsp,
   input  logic                  out_full,
   output logic                  out_push,
   output bmla_pkg::rsp_type     out_data
);
   import bmla_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DIFF, S_SQ, S_SQRT, S_ATTEN, S_ATTEN_WAIT,
      S_SCALE, S_NORM, S_NORM_WAIT, S_LIGHT, S_EMIT
   } state_type;

   state_type          state_ff;
   req_type            item_ff;
   rgb_type            accum_ff [NUM_FACES];
   rgb_type            col_ff;
   logic signed [31:0] dx_ff, dy_ff, dz_ff;
   logic signed [31:0] lx_ff, ly_ff, lz_ff;
   logic [63:0]        dsq_ff, sq_n_ff, sq_res_ff, sq_bit_ff;
   logic [31:0]        dist_ff;
   logic [ATT_W-1:0]   atten_ff;
   logic [30:0]        w_ff;
   logic [2:0]         cnt_ff, face_ff;
   logic signed [65:0] prod_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [31:0] axis_v, cur_d;
   logic signed [32:0] proj;
   logic [31:0]        mag, dpos;
   logic signed [32:0] dgap;
   logic [30:0]        span;
   logic [63:0]        sq_sum, dsq_total;
   logic signed [65:0] prod_sh;
   logic [65:0]        prod_ush;
   logic signed [31:0] acc_cur, col_cur, scaled;
   logic signed [49:0] acc_sum;
   logic [DIV_W-1:0]   q_neg;
   logic [31:0]        q32;

   function automatic logic signed [31:0] pick(input rgb_type c, input logic [1:0] i);
      unique case (i)
         2'd0:    return c.r;
         2'd1:    return c.g;
         default: return c.b;
      endcase
   endfunction

   function automatic logic signed [32:0] ext33(input logic signed [31:0] v);
      return {v[31], v};
   endfunction

   // projection of the light direction onto the current face axis
   always_comb begin
      unique case (face_ff[2:1])
         2'd0:    axis_v = lx_ff;
         2'd1:    axis_v = ly_ff;
         default: axis_v = lz_ff;
      endcase
      if (!face_ff[0]) begin
         proj = (axis_v > 0) ? ext33(axis_v) : 33'sd0;
      end else begin
         proj = (axis_v < 0) ? -ext33(axis_v) : 33'sd0;
      end
   end

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    cur_d = dx_ff;
         2'd1:    cur_d = dy_ff;
         default: cur_d = dz_ff;
      endcase
      mag  = cur_d[31] ? (~cur_d + 32'd1) : cur_d;
      // root is final once the sqrt steps end, dist_ff only follows it
      dgap = $signed({1'b0, sq_res_ff[31:0]}) - $signed({2'b00, item_ff.falloff_start});
      dpos = dgap[32] ? 32'd0 : dgap[31:0];
      span = item_ff.light_range - item_ff.falloff_start;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      priority case (state_ff)
         S_SQ: begin
            mul_a = ext33(cur_d);
            mul_b = ext33(cur_d);
         end
         S_SCALE: begin
            mul_a = ext33(pick({item_ff.red, item_ff.green, item_ff.blue}, cnt_ff[1:0]));
            mul_b = $signed({{(33 - ATT_W){1'b0}}, atten_ff});
         end
         S_LIGHT: begin
            if (cnt_ff == 3'd0) begin
               mul_a = proj;
               mul_b = proj;
            end else begin
               mul_a = $signed({2'b00, w_ff});
               mul_b = ext33(pick(col_ff, 2'(cnt_ff - 3'd2)));
            end
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      sq_sum    = sq_res_ff + sq_bit_ff;
      dsq_total = dsq_ff + prod_ff[63:0];
      prod_sh   = prod_ff >>> FRAC_BITS;
      prod_ush  = 66'(prod_ff) >> FRAC_BITS;
      scaled    = prod_sh[31:0];
      acc_cur   = pick(accum_ff[face_ff], 2'(cnt_ff - 3'd3));
      acc_sum   = {{18{acc_cur[31]}}, acc_cur} + prod_sh[49:0];
      q_neg     = ~div_rsp.quotient + DIV_W'(1);
      q32       = cur_d[31] ? q_neg[31:0] : div_rsp.quotient[31:0];
   end

   assign cmd_pop          = (state_ff == S_IDLE) && cmd_valid;
   assign div_req.start    = (state_ff == S_ATTEN) || (state_ff == S_NORM);
   assign div_req.dividend = (state_ff == S_ATTEN) ? (DIV_W'(dpos) << FRAC_BITS)
                                                   : (DIV_W'(mag) << FRAC_BITS);
   assign div_req.divisor  = (state_ff == S_ATTEN) ? {1'b0, span} : dist_ff;
   assign out_push         = (state_ff == S_EMIT) && !out_full;

   always_comb begin
      out_data.out_face  = face_ff;
      out_data.out_red   = accum_ff[face_ff].r;
      out_data.out_green = accum_ff[face_ff].g;
      out_data.out_blue  = accum_ff[face_ff].b;
      out_data.last      = face_ff == 3'(NUM_FACES - 1);
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         face_ff  <= '0;
         for (int i = 0; i < NUM_FACES; i++) accum_ff[i] <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  item_ff <= cmd.item;
                  cnt_ff  <= '0;
                  face_ff <= '0;
                  unique case (cmd.item.kind)
                     KIND_LOAD: begin
                        if (cmd.load_ok) begin
                           accum_ff[cmd.item.face] <=
                              {cmd.item.red, cmd.item.green, cmd.item.blue};
                        end
                     end
                     KIND_DIR: begin
                        lx_ff    <= cmd.item.vec_x;
                        ly_ff    <= cmd.item.vec_y;
                        lz_ff    <= cmd.item.vec_z;
                        col_ff   <= {cmd.item.red, cmd.item.green, cmd.item.blue};
                        state_ff <= S_LIGHT;
                     end
                     KIND_POINT: begin
                        if (!cmd.point_skip) state_ff <= S_DIFF;
                     end
                     KIND_EMIT: state_ff <= S_EMIT;
                  endcase
               end
            end
            S_DIFF: begin
               dx_ff    <= sat32(50'(ext33(item_ff.vec_x) - ext33(view_x)));
               dy_ff    <= sat32(50'(ext33(item_ff.vec_y) - ext33(view_y)));
               dz_ff    <= sat32(50'(ext33(item_ff.vec_z) - ext33(view_z)));
               cnt_ff   <= '0;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               // product of the previous cycle's component lands here
               if (cnt_ff == 3'd0) begin
                  dsq_ff <= '0;
               end else begin
                  dsq_ff <= dsq_total;
               end
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  sq_n_ff   <= dsq_total;
                  sq_res_ff <= '0;
                  sq_bit_ff <= 64'd1 << 62;
                  state_ff  <= (dsq_total == 64'd0) ? S_IDLE : S_SQRT;
               end
            end
            S_SQRT: begin
               if (sq_n_ff >= sq_sum) begin
                  sq_n_ff   <= sq_n_ff - sq_sum;
                  sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
               if (sq_bit_ff[0]) state_ff <= S_ATTEN;
            end
            S_ATTEN: begin
               dist_ff  <= sq_res_ff[31:0];
               state_ff <= S_ATTEN_WAIT;
            end
            S_ATTEN_WAIT: begin
               if (div_rsp.done) begin
                  if (div_rsp.quotient >= DIV_W'(ONE)) begin
                     atten_ff <= '0;
                  end else begin
                     atten_ff <= ATT_W'(ONE) - ATT_W'(div_rsp.quotient);
                  end
                  cnt_ff   <= '0;
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               unique case (cnt_ff[1:0])
                  2'd1:    col_ff.r <= scaled;
                  2'd2:    col_ff.g <= scaled;
                  2'd3:    col_ff.b <= scaled;
                  default: ;
               endcase
               if (cnt_ff == 3'd3) begin
                  cnt_ff   <= '0;
                  state_ff <= S_NORM;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_NORM: state_ff <= S_NORM_WAIT;
            S_NORM_WAIT: begin
               if (div_rsp.done) begin
                  unique case (cnt_ff[1:0])
                     2'd0:    lx_ff <= q32;
                     2'd1:    ly_ff <= q32;
                     default: lz_ff <= q32;
                  endcase
                  if (cnt_ff == 3'd2) begin
                     cnt_ff   <= '0;
                     face_ff  <= '0;
                     state_ff <= S_LIGHT;
                  end else begin
                     cnt_ff   <= cnt_ff + 3'd1;
                     state_ff <= S_NORM;
                  end
               end
            end
            S_LIGHT: begin
               // weight, three channel products, then three saturating adds
               if (cnt_ff == 3'd1) begin
                  w_ff <= (prod_ush[65:31] != '0) ? 31'h7FFFFFFF : prod_ush[30:0];
               end
               unique case (cnt_ff)
                  3'd3:    accum_ff[face_ff].r <= sat32(acc_sum);
                  3'd4:    accum_ff[face_ff].g <= sat32(acc_sum);
                  3'd5:    accum_ff[face_ff].b <= sat32(acc_sum);
                  default: ;
               endcase
               if (cnt_ff == 3'd5) begin
                  cnt_ff <= '0;
                  if (face_ff == 3'(NUM_FACES - 1)) begin
                     state_ff <= S_IDLE;
                  end else begin
                     face_ff <= face_ff + 3'd1;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_EMIT: begin
               if (!out_full) begin
                  if (face_ff == 3'(NUM_FACES - 1)) begin
                     state_ff <= S_IDLE;
                  end else begin
                     face_ff <= face_ff + 3'd1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== hdl/box_map_light_accumulate.sv =====
// Ambient-cube light accumulator, Q15.16. Items enter a four-entry command
// queue and are executed one at a time by a sequencer; results leave through
// an eight-entry queue. Every item is first taken from the command queue by
// the idle state; a load needs nothing more. An emit then writes the six
// faces (one face per cycle while the result queue has room), a directional
// light updates six faces (one weight multiply and three colour multiplies
// each on a single shared 33x33 multiplier). A point light adds the 32-step
// square root and four passes of the shared divider (falloff and three
// direction components) on top of the face update. Skipped point lights
// need nothing beyond being taken from the queue.
// The view position registers sit at byte addresses 0, 4 and 8.
module box_map_light_accumulate (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  bmla_pkg::req_type req_item,
   output logic              empty,
   input  logic              pop,
   output bmla_pkg::rsp_type rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import bmla_pkg::*;

   logic signed [31:0] view_x_ff, view_y_ff, view_z_ff;
   logic               csr_write;
   reg_index_type      csr_index;
   logic               cmd_valid, cmd_pop;
   cmd_type            cmd;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic               out_full, out_push;
   rsp_type            out_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_comb begin
      unique case (csr_index)
         REG_VIEW_X: prdata = view_x_ff;
         REG_VIEW_Y: prdata = view_y_ff;
         REG_VIEW_Z: prdata = view_z_ff;
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_x_ff <= '0;
         view_y_ff <= '0;
         view_z_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_VIEW_X: view_x_ff <= pwdata;
            REG_VIEW_Y: view_y_ff <= pwdata;
            REG_VIEW_Z: view_z_ff <= pwdata;
            default: ;
         endcase
      end
   end

   bmla_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   bmla_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   bmla_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .view_x    (view_x_ff),
      .view_y    (view_y_ff),
      .view_z    (view_z_ff),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   bmla_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .in_push  (out_push),
      .in_data  (out_data),
      .in_full  (out_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

// ===== hdl/bmla_checker.sv =====
module bmla_checker (
   input logic              clock,
   input logic              reset,
   input logic              full,
   input logic              empty,
   input logic              pop,
   input logic              pready,
   input bmla_pkg::rsp_type rsp_item
);
   import bmla_pkg::*;

   assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not cleared by reset");

   assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_item.last |-> rsp_item.out_face == 3'(NUM_FACES - 1))
      else $error("last flag on a face other than the final one");

   assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_item.out_face == 3'(NUM_FACES - 1) |-> rsp_item.last)
      else $error("final face without last flag");

   assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_item))
      else $error("waiting result changed before transfer");

   assert property (@(posedge clock) pready)
      else $error("pready dropped");

endmodule

bind box_map_light_accumulate bmla_checker u_bmla_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .pready   (pready),
   .rsp_item (rsp_item)
);
